// ===== rtl/uwt_pkg.sv =====
// ----------------------------------------------------------------------------
// uwt_pkg
// Shared types and constants for the unique word table.
// ----------------------------------------------------------------------------
package uwt_pkg;

	localparam int UWT_WORD_SLOTS = 16;
	localparam int UWT_WORD_CHARS = 8;

	localparam int OPC_W    = 3;
	localparam int KEY_W    = 64;
	localparam int POS_W    = 4;
	localparam int STAT_W   = 3;
	localparam int NARROW_W = 5;

	typedef enum logic [OPC_W-1:0] {
		OP_ADD    = 3'd0,
		OP_DELETE = 3'd1,
		OP_SEARCH = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_DUP    = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_BADIDX = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} uwt_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} uwt_cmd_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [NARROW_W-1:0] found_index;
		logic [KEY_W-1:0]    word_out;
		logic [NARROW_W-1:0] entry_count;
	} out_item_t;

endpackage

// ===== rtl/uwt_in_if.sv =====
// ----------------------------------------------------------------------------
// uwt_in_if
// Request channel: valid/ready handshake carrying one table operation.
// ----------------------------------------------------------------------------
interface uwt_in_if;
	logic               valid;
	logic               ready;
	uwt_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/uwt_out_if.sv =====
// ----------------------------------------------------------------------------
// uwt_out_if
// Result channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface uwt_out_if;
	logic               valid;
	logic               ready;
	uwt_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/uwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// uwt_ctrl
// Sequencer: capture one request, commit it once the result register is free.
// ----------------------------------------------------------------------------
module uwt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output uwt_pkg::uwt_cmd_t cmd
);
	import uwt_pkg::*;

	uwt_state_t state_q;
	uwt_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register is empty or draining
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/uwt_dpath.sv =====
// ----------------------------------------------------------------------------
// uwt_dpath
// Word cells with per-cell compare, shift-down delete and the result register.
// ----------------------------------------------------------------------------
module uwt_dpath #(
	parameter int WORD_SLOTS = uwt_pkg::UWT_WORD_SLOTS,
	parameter int WORD_CHARS = uwt_pkg::UWT_WORD_CHARS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  uwt_pkg::uwt_cmd_t  cmd,
	input  uwt_pkg::in_item_t  req,
	output uwt_pkg::out_item_t rsp
);
	import uwt_pkg::*;

	localparam int CELL_W = 8 * WORD_CHARS;
	localparam int SLOT_W = $clog2(WORD_SLOTS);
	localparam int CNT_W  = $clog2(WORD_SLOTS + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CELL_W-1:0]   cell_q [WORD_SLOTS];
	logic [CNT_W-1:0]    count_q;

	logic [OPC_W-1:0]    op_s1;
	logic [POS_W-1:0]    pos_s1;
	logic [CELL_W-1:0]   key_s1;
	logic [WORD_SLOTS-1:0] hit_s1;

	logic [CELL_W-1:0]   key_norm;
	logic [WORD_SLOTS-1:0] hit;

	logic [SLOT_W-1:0]   hit_idx;
	logic                hit_any;
	logic [CMP_W-1:0]    pos_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic [CELL_W-1:0]   rd_word;
	logic                full;

	status_t             status;
	logic [CNT_W-1:0]    found;
	logic [KEY_W-1:0]    word;
	logic [CNT_W-1:0]    count_d;
	logic                do_add;
	logic                do_del;

	out_item_t           rsp_q;

	// Keep only the word up to its first zero byte.
	always_comb begin
		logic alive;
		alive    = 1'b1;
		key_norm = '0;
		for (int b = 0; b < WORD_CHARS; b++) begin
			if (req.key[8*b +: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				key_norm[8*b +: 8] = req.key[8*b +: 8];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WORD_SLOTS; i++) begin
			hit[i] = (cell_q[i] == key_norm) && (CNT_W'(i) < count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1  <= req.opcode;
			pos_s1 <= req.position;
			key_s1 <= key_norm;
			hit_s1 <= hit;
		end
	end

	// Keys are unique, so at most one valid cell hits: OR the indexes together.
	always_comb begin
		hit_idx = '0;
		hit_any = 1'b0;
		for (int i = 0; i < WORD_SLOTS; i++) begin
			if (hit_s1[i]) begin
				hit_idx = hit_idx | SLOT_W'(i);
				hit_any = 1'b1;
			end
		end
	end

	assign pos_ext = CMP_W'(pos_s1);
	assign cnt_ext = CMP_W'(count_q);
	assign full    = (count_q == CNT_W'(WORD_SLOTS));

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < WORD_SLOTS; i++) begin
			if (CMP_W'(i) == pos_ext) begin
				rd_word = cell_q[i];
			end
		end
	end

	always_comb begin
		status  = ST_OK;
		found   = '0;
		word    = '0;
		count_d = count_q;
		do_add  = 1'b0;
		do_del  = 1'b0;
		case (opcode_t'(op_s1))
			OP_ADD: begin
				if (full) begin
					status = ST_FULL;
				end else if (hit_any) begin
					status = ST_DUP;
				end else begin
					do_add  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status = ST_BADIDX;
				end else begin
					do_del  = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				found = hit_any ? CNT_W'(hit_idx) : count_q;
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					status = ST_BADIDX;
				end else begin
					word = KEY_W'(rd_word);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	// Cells past the count are never read, so they need no reset or clearing.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_add) begin
			cell_q[count_q[SLOT_W-1:0]] <= key_s1;
		end else if (cmd.commit && do_del) begin
			for (int i = 0; i < WORD_SLOTS - 1; i++) begin
				if (CMP_W'(i) >= pos_ext) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status      <= status;
			rsp_q.found_index <= NARROW_W'(found);
			rsp_q.word_out    <= word;
			rsp_q.entry_count <= NARROW_W'(count_d);
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/unique_word_table.sv =====
// Each request transfer is captured, then committed; the result registers on commit.
// No request is taken before the last commits; the cell compare runs in the capture
// cycle and the table update in the commit cycle, so a request waits for both.
// A held result stalls the commit cycle until the result transfer frees it.
// Reset: asynchronous, active low; empties the table (count to zero) and drops
// any pending result. No clearing pass: cells at or above the count are ignored.
// ----------------------------------------------------------------------------
// unique_word_table
// Compacted table of unique short words: add, delete, search, clear, read.
// ----------------------------------------------------------------------------
module unique_word_table #(
	parameter int WORD_SLOTS = uwt_pkg::UWT_WORD_SLOTS,
	parameter int WORD_CHARS = uwt_pkg::UWT_WORD_CHARS
) (
	input  logic        clk,
	input  logic        arst_n,
	uwt_in_if.sink      item,
	uwt_out_if.source   result
);
	import uwt_pkg::*;

	uwt_cmd_t cmd;

	// Controller: two-state sequencer plus the result valid flag.
	// A new request transfer is taken only in idle; the commit step waits
	// while an earlier result is still held and not being taken.
	uwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// Datapath: word cells with one comparator each, the entry count,
	// the captured request and the result register.
	// On capture every valid cell compares against the normalized key;
	// on commit the operation updates cells and count and loads the result.
	uwt_dpath #(
		.WORD_SLOTS (WORD_SLOTS),
		.WORD_CHARS (WORD_CHARS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (item.payload),
		.rsp    (result.payload)
	);

endmodule

// ===== tb/sv/word_table_checker.sv =====
// ----------------------------------------------------------------------------
// word_table_checker
// Watches both channels of the unique word table, keeps a shadow copy of the
// table, predicts one result per request transfer and compares every result
// transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module word_table_checker (
	input  logic clk,
	input  logic arst_n,
	uwt_in_if    item,
	uwt_out_if   result,
	output int   results_owed,
	output int   mismatches
);
	import uwt_pkg::*;

	logic [KEY_W-1:0] shadow_words [UWT_WORD_SLOTS];
	int unsigned      shadow_count;
	out_item_t        replies_due [$];
	int               fail_tally;

	// Keep the low WORD_CHARS bytes up to the first zero byte; zero the rest.
	function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] word;
		word = '0;
		for (int b = 0; b < UWT_WORD_CHARS; b++) begin
			if (raw[8*b +: 8] == 8'h00)
				break;
			word[8*b +: 8] = raw[8*b +: 8];
		end
		return word;
	endfunction

	// Index of the word among the live entries, or the count when absent.
	function automatic int unsigned locate_word(logic [KEY_W-1:0] word);
		for (int unsigned i = 0; i < shadow_count; i++)
			if (shadow_words[i] == word)
				return i;
		return shadow_count;
	endfunction

	function automatic out_item_t apply_table_op(in_item_t req);
		out_item_t        reply;
		logic [KEY_W-1:0] word;
		int unsigned      pos;
		reply = '0;
		reply.status = ST_OK;
		word = trim_key(req.key);
		pos = req.position;
		case (req.opcode)
			OP_ADD: begin
				// fullness wins over duplication
				if (shadow_count >= UWT_WORD_SLOTS)
					reply.status = ST_FULL;
				else if (locate_word(word) < shadow_count)
					reply.status = ST_DUP;
				else begin
					shadow_words[shadow_count] = word;
					shadow_count++;
				end
			end
			OP_DELETE: begin
				if (shadow_count == 0)
					reply.status = ST_EMPTY;
				else if (pos >= shadow_count)
					reply.status = ST_BADIDX;
				else begin
					for (int unsigned i = pos; i + 1 < shadow_count; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_count--;
					shadow_words[shadow_count] = '0;
				end
			end
			OP_SEARCH: begin
				reply.found_index = NARROW_W'(locate_word(word));
			end
			OP_CLEAR: begin
				for (int i = 0; i < UWT_WORD_SLOTS; i++)
					shadow_words[i] = '0;
				shadow_count = 0;
			end
			OP_READ: begin
				if (pos >= shadow_count)
					reply.status = ST_BADIDX;
				else
					reply.word_out = shadow_words[pos];
			end
			default: begin
			end
		endcase
		reply.entry_count = NARROW_W'(shadow_count);
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			for (int i = 0; i < UWT_WORD_SLOTS; i++)
				shadow_words[i] = '0;
			shadow_count = 0;
			replies_due.delete();
			fail_tally = 0;
			results_owed <= 0;
			mismatches <= 0;
		end else begin
			// retire the result first; it always belongs to an older request
			if (result.valid && result.ready) begin
				got = result.payload;
				if (replies_due.size() == 0) begin
					$error("result transfer with no request outstanding");
					fail_tally++;
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_tally++;
					end
					if (got.found_index !== want.found_index) begin
						$error("found_index: expected %0d, got %0d",
							want.found_index, got.found_index);
						fail_tally++;
					end
					if (got.word_out !== want.word_out) begin
						$error("word_out: expected %h, got %h", want.word_out, got.word_out);
						fail_tally++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						fail_tally++;
					end
				end
			end
			if (item.valid && item.ready)
				replies_due.push_back(apply_table_op(item.payload));
			results_owed <= replies_due.size();
			mismatches <= fail_tally;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the unique word table: a directed pass over the
// corner cases, then phases of random operations weighted to grow, churn or
// shrink the table, with random idling on both channels. The checker beside
// the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import uwt_pkg::*;

	// Opcodes past the last defined one; the block must treat them as no-ops.
	localparam logic [OPC_W-1:0] OP_SPARE_FIRST = OPC_W'(int'(OP_READ) + 1);
	localparam logic [OPC_W-1:0] OP_SPARE_LAST  = '1;

	localparam int VOCAB_SIZE     = 24;   // a bit more words than slots
	localparam int PHASE_COUNT    = 9;
	localparam int PHASE_ITEMS    = 100;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// Keys for the directed part. The padded forms carry junk past the first
	// zero byte, so all of them name the same one-letter word.
	localparam logic [KEY_W-1:0] KEY_EMPTY      = '0;
	localparam logic [KEY_W-1:0] KEY_ALL_ONES   = '1;
	localparam logic [KEY_W-1:0] KEY_A          = 64'h0000_0000_0000_0041;
	localparam logic [KEY_W-1:0] KEY_A_PADDED   = 64'hDEAD_BEEF_0000_0041;
	localparam logic [KEY_W-1:0] KEY_A_PADDED_2 = 64'hFFFF_FFFF_FF00_0041;
	localparam logic [POS_W-1:0] POS_FIRST      = '0;
	localparam logic [POS_W-1:0] POS_LAST       = '1;

	typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} op_mix_t;

	logic clk;
	logic arst_n;

	uwt_in_if  item_ch ();
	uwt_out_if result_ch ();

	int results_owed;
	int mismatches;

	// Idling controls; a quiet side never idles during the current phase.
	bit source_quiet;
	bit sink_quiet;
	int stall_left;
	int idle_cycles;

	// Word pool: normalized words and their lengths in characters.
	logic [KEY_W-1:0] vocab_word [VOCAB_SIZE];
	int               vocab_len  [VOCAB_SIZE];

	unique_word_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	word_table_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.results_owed (results_owed),
		.mismatches   (mismatches)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Mostly short idles, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Either a fully random key, so every key bit toggles, or a pool word with
	// optional junk above its terminating zero byte, so adds collide and
	// searches hit.
	function automatic logic [KEY_W-1:0] pick_key();
		int               idx;
		logic [KEY_W-1:0] key;
		if ($urandom_range(0, 99) < 15)
			return {$urandom, $urandom};
		idx = $urandom_range(0, VOCAB_SIZE - 1);
		key = vocab_word[idx];
		if (vocab_len[idx] < 7 && $urandom_range(0, 1) == 1)
			key |= {$urandom, $urandom} << (8 * (vocab_len[idx] + 1));
		return key;
	endfunction

	function automatic logic [OPC_W-1:0] pick_op(op_mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GROW: begin
				if (r < 60) return OP_ADD;
				if (r < 72) return OP_SEARCH;
				if (r < 84) return OP_READ;
				if (r < 94) return OP_DELETE;
				if (r < 95) return OP_CLEAR;
			end
			MIX_CHURN: begin
				if (r < 35) return OP_ADD;
				if (r < 60) return OP_DELETE;
				if (r < 75) return OP_SEARCH;
				if (r < 90) return OP_READ;
				if (r < 93) return OP_CLEAR;
			end
			default: begin
				if (r < 50) return OP_DELETE;
				if (r < 65) return OP_ADD;
				if (r < 77) return OP_SEARCH;
				if (r < 92) return OP_READ;
				if (r < 94) return OP_CLEAR;
			end
		endcase
		return OPC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
	endfunction

	// Present one request and hold it until its transfer. Valid stays high
	// into the next request unless an idle gap drops it first.
	task automatic issue_op(logic [OPC_W-1:0] op, logic [KEY_W-1:0] key,
			logic [POS_W-1:0] pos);
		in_item_t req;
		int       gap;
		gap = 0;
		if (!source_quiet && $urandom_range(0, 99) < 35)
			gap = idle_len();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.opcode   = op;
		req.key      = key;
		req.position = pos;
		item_ch.valid   <= 1'b1;
		item_ch.payload <= req;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	// The first edge lets the checker count the last transfer.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (results_owed != 0);
	endtask

	// Result sink: random stalls, none while the sink is quiet.
	initial begin
		result_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if (!sink_quiet && $urandom_range(0, 99) < 30)
					stall_left = idle_len();
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[unique_word_table] ERROR");
				$finish;
			end
		end
	end

	initial begin
		op_mix_t mix;
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		source_quiet    = 1'b0;
		sink_quiet      = 1'b0;

		// Build the word pool; entry zero is the empty word.
		for (int i = 0; i < VOCAB_SIZE; i++) begin
			vocab_len[i]  = (i == 0) ? 0 : $urandom_range(1, UWT_WORD_CHARS);
			vocab_word[i] = '0;
			for (int b = 0; b < vocab_len[i]; b++)
				vocab_word[i][8*b +: 8] = 8'($urandom_range(1, 255));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table: search misses at index zero, delete reports empty,
		// read reports a bad index, clear is a plain success.
		issue_op(OP_SEARCH, KEY_EMPTY, POS_FIRST);
		issue_op(OP_DELETE, KEY_EMPTY, POS_FIRST);
		issue_op(OP_READ, KEY_EMPTY, POS_FIRST);
		issue_op(OP_CLEAR, KEY_EMPTY, POS_FIRST);
		issue_op(OP_SPARE_FIRST, KEY_ALL_ONES, POS_LAST);

		// The empty word is a legal entry; junk after the first zero byte
		// must not make the same word look new.
		issue_op(OP_ADD, KEY_EMPTY, POS_FIRST);
		issue_op(OP_ADD, KEY_ALL_ONES, POS_LAST);
		issue_op(OP_ADD, KEY_A_PADDED, POS_FIRST);
		issue_op(OP_ADD, KEY_A, POS_FIRST);
		issue_op(OP_SEARCH, KEY_A_PADDED_2, POS_FIRST);
		issue_op(OP_READ, KEY_EMPTY, 4'd1);
		issue_op(OP_READ, KEY_EMPTY, POS_LAST);

		// Delete past the count, then from the head so later entries shift.
		issue_op(OP_DELETE, KEY_EMPTY, 4'd3);
		issue_op(OP_DELETE, KEY_ALL_ONES, POS_FIRST);
		issue_op(OP_SPARE_LAST, KEY_A, POS_FIRST);
		issue_op(OP_SEARCH, KEY_EMPTY, POS_FIRST);
		issue_op(OP_DELETE, KEY_EMPTY, POS_LAST);
		issue_op(OP_CLEAR, KEY_ALL_ONES, POS_LAST);
		drain_results();

		// Random phases. Grow phases fill the table, so full-table adds and
		// duplicate adds on a full table come up; shrink phases empty it.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			source_quiet = (phase == 2 || phase == 5);
			sink_quiet   = (phase == 2 || phase == 7);
			mix = op_mix_t'(phase % 3);
			repeat (PHASE_ITEMS)
				issue_op(pick_op(mix), pick_key(), POS_W'($urandom_range(0, 15)));
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[unique_word_table] OK");
		else
			$display("[unique_word_table] ERROR");
		$finish;
	end

endmodule
